@@ hw/rtl/eemrx_pkg.sv @@
// ----------------------------------------------------------------------------
// eemrx_pkg
// Shared types and constants for the EEM receive deframer.
// ----------------------------------------------------------------------------
package eemrx_pkg;

   localparam int unsigned CRC_FIELD_BYTES = 4;
   localparam int unsigned CMD_LEN_W       = 11;
   localparam int unsigned DATA_LEN_W      = 14;
   localparam int unsigned OUTQ_DEPTH      = 4;
   localparam int unsigned OUTQ_PTR_W      = $clog2(OUTQ_DEPTH);
   localparam int unsigned OUTQ_CNT_W      = $clog2(OUTQ_DEPTH + 1);

   localparam logic [DATA_LEN_W-1:0] CRC_LEN = DATA_LEN_W'(CRC_FIELD_BYTES);

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_ABORT   = 2'd2,
      KIND_BAD_LEN = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      PH_HDR_LO  = 5'b00001,
      PH_HDR_HI  = 5'b00010,
      PH_CMD     = 5'b00100,
      PH_DATA    = 5'b01000,
      PH_DISCARD = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      kind_type   kind;
      logic       frame_start;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic    v0;
      logic    v1;
      rsp_type r0;
      rsp_type r1;
   } pair_type;

   function automatic rsp_type make_rsp(logic [7:0] data, kind_type kind, logic start);
      rsp_type r;
      r.payload_byte = data;
      r.kind         = kind;
      r.frame_start  = start;
      r.run_last     = 1'b0;
      return r;
   endfunction

endpackage

@@ hw/rtl/eem_receive_deframer_core.sv @@
// ----------------------------------------------------------------------------
// eem_receive_deframer_core
// EEM receive deframer: USB buffer bytes in, Ethernet payload and status out.
// ----------------------------------------------------------------------------
// One received byte is taken per beat and parsed while it sits in the input
// register, so a byte can be accepted every cycle if not held. A byte yields at
// most two results (payload then frame complete or aborted) and the result
// channel drains one per beat through a four-entry queue; parsing a byte waits
// until that queue has room for two, which sets the sustained rate to one byte
// per cycle unless results pile up at two per byte.
module eem_receive_deframer_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  eemrx_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output eemrx_pkg::rsp_type rsp_payload
);
   import eemrx_pkg::*;

   logic     in_vld_ff, in_vld_in;
   req_type  in_ff;
   logic     fire;
   logic     space;
   pair_type pair;

   assign fire      = in_vld_ff && space;
   assign req_ready = !in_vld_ff || fire;
   assign in_vld_in = (req_valid && req_ready) || (in_vld_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_payload;
      end
   end

   eemrx_parse u_parse (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .beat  (in_ff),
      .pair  (pair)
   );

   eemrx_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .push        (fire),
      .pair        (pair),
      .space       (space),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   a_status_ends_run : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind != KIND_PAYLOAD |-> rsp_payload.run_last)
      else $error("status result not marked last of its run");

   a_start_is_payload : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_start |-> rsp_payload.kind == KIND_PAYLOAD)
      else $error("frame start on non-payload result");

   a_pair_order : assert property (@(posedge clock) disable iff (reset)
      fire && pair.v1 |-> pair.v0 && pair.r0.kind == KIND_PAYLOAD)
      else $error("second result without a leading payload byte");

   a_held_beat : assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !fire |=> in_vld_ff && $stable(in_ff))
      else $error("stalled input beat lost or changed");

endmodule

@@ hw/rtl/eemrx_parse.sv @@
// ----------------------------------------------------------------------------
// eemrx_parse
// Header parser and packet state; turns one beat into up to two results.
// ----------------------------------------------------------------------------
module eemrx_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  eemrx_pkg::req_type beat,
   output eemrx_pkg::pair_type pair
);
   import eemrx_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [7:0]            hlo_ff, hlo_in;
   logic [DATA_LEN_W-1:0] left_ff, left_in;
   logic                  first_ff, first_in;

   logic [15:0]           hdr;
   logic [DATA_LEN_W-1:0] left_dec;
   logic                  pay;
   logic                  term;
   kind_type              term_kind;

   assign hdr      = {beat.rx_byte, hlo_ff};
   assign left_dec = left_ff - DATA_LEN_W'(1);
   assign pay      = left_ff > CRC_LEN;

   always_comb begin
      term      = 1'b0;
      term_kind = KIND_DONE;
      if (left_dec == '0) begin
         term = 1'b1;
      end else if (beat.buffer_end) begin
         term      = 1'b1;
         term_kind = KIND_ABORT;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      hlo_in   = hlo_ff;
      left_in  = left_ff;
      first_in = first_ff;
      pair     = '0;
      case (phase_ff)
         PH_HDR_LO: begin
            hlo_in   = beat.rx_byte;
            phase_in = beat.buffer_end ? PH_HDR_LO : PH_HDR_HI;
         end
         PH_HDR_HI: begin
            phase_in = PH_HDR_LO;
            if (hdr != 16'h0000) begin
               if (hdr[15]) begin
                  if (hdr[CMD_LEN_W-1:0] != '0 && !beat.buffer_end) begin
                     left_in  = DATA_LEN_W'(hdr[CMD_LEN_W-1:0]);
                     phase_in = PH_CMD;
                  end
               end else if (hdr[DATA_LEN_W-1:0] <= CRC_LEN) begin
                  pair.v0 = 1'b1;
                  pair.r0 = make_rsp(8'h00, KIND_BAD_LEN, 1'b0);
                  if (!beat.buffer_end) begin
                     phase_in = PH_DISCARD;
                  end
               end else if (!beat.buffer_end) begin
                  left_in  = hdr[DATA_LEN_W-1:0];
                  first_in = 1'b1;
                  phase_in = PH_DATA;
               end
            end
         end
         PH_CMD: begin
            left_in = left_dec;
            if (left_dec == '0 || beat.buffer_end) begin
               phase_in = PH_HDR_LO;
            end
         end
         PH_DATA: begin
            left_in = left_dec;
            if (term) begin
               phase_in = PH_HDR_LO;
            end
            if (pay) begin
               first_in = 1'b0;
               pair.v0  = 1'b1;
               pair.r0  = make_rsp(beat.rx_byte, KIND_PAYLOAD, first_ff);
               if (term) begin
                  pair.v1 = 1'b1;
                  pair.r1 = make_rsp(8'h00, term_kind, 1'b0);
               end
            end else if (term) begin
               pair.v0 = 1'b1;
               pair.r0 = make_rsp(8'h00, term_kind, 1'b0);
            end
         end
         PH_DISCARD: begin
            if (beat.buffer_end) begin
               phase_in = PH_HDR_LO;
            end
         end
         default: begin
            phase_in = PH_HDR_LO;
         end
      endcase
      if (pair.v1) begin
         pair.r1.run_last = 1'b1;
      end else if (pair.v0) begin
         pair.r0.run_last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR_LO;
         hlo_ff   <= '0;
         left_ff  <= '0;
         first_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         hlo_ff   <= hlo_in;
         left_ff  <= left_in;
         first_ff <= first_in;
      end
   end

endmodule

@@ hw/rtl/eemrx_outq.sv @@
// ----------------------------------------------------------------------------
// eemrx_outq
// Small result queue: takes up to two results a cycle, drains one a beat.
// ----------------------------------------------------------------------------
module eemrx_outq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  eemrx_pkg::pair_type pair,
   output logic                space,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output eemrx_pkg::rsp_type  rsp_payload
);
   import eemrx_pkg::*;

   rsp_type               ent_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUTQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_CNT_W-1:0] count_ff, count_in;
   logic [OUTQ_CNT_W-1:0] n_push;
   logic [OUTQ_PTR_W-1:0] wr_ptr_nxt;
   logic                  pop;

   assign pop         = rsp_valid && rsp_ready;
   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = ent_ff[rd_ptr_ff];
   assign space       = count_ff <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
   assign wr_ptr_nxt  = wr_ptr_ff + OUTQ_PTR_W'(1);

   always_comb begin
      n_push = '0;
      if (push) begin
         n_push = OUTQ_CNT_W'(pair.v0) + OUTQ_CNT_W'(pair.v1);
      end
      wr_ptr_in = wr_ptr_ff + OUTQ_PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + OUTQ_PTR_W'(pop);
      count_in  = count_ff + n_push - OUTQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push && pair.v0) begin
         ent_ff[wr_ptr_ff] <= pair.r0;
      end
      if (push && pair.v1) begin
         ent_ff[wr_ptr_nxt] <= pair.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
